/* rtl/pslc_pkg.sv */
// Package for the press stroke lot counter: words, control structs, constants.
`timescale 1ns / 1ps

package pslc_pkg;

    localparam int CNT_W  = 24;
    localparam int LIFE_W = 48;
    localparam int CMD_W  = 16;
    localparam int IDX_W  = 3;

    localparam logic [CNT_W-1:0] COUNT_MAX = 24'd9999999;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_PRESENT     = 3'd0;
    localparam logic [IDX_W-1:0] REG_IN_USE      = 3'd1;
    localparam logic [IDX_W-1:0] REG_EXTERNAL    = 3'd2;
    localparam logic [IDX_W-1:0] REG_LOT1_PRESET = 3'd3;
    localparam logic [IDX_W-1:0] REG_LOT2_PRESET = 3'd4;
    localparam logic [IDX_W-1:0] REG_SHOW_REMAIN = 3'd5;

    // Command word bit positions
    localparam int CMD_TOTAL_COUNT = 2;
    localparam int CMD_TOTAL_RESET = 3;
    localparam int CMD_TOTAL2_RESET = 7;
    localparam int CMD_LOT1_COUNT  = 10;
    localparam int CMD_LOT1_RESET  = 11;
    localparam int CMD_LOT2_COUNT  = 14;
    localparam int CMD_LOT2_RESET  = 15;

    typedef struct packed {
        logic             stroke_event;
        logic [CMD_W-1:0] command_word;
        logic [1:0]       lot_reached;
    } in_word_t;

    typedef struct packed {
        logic [CNT_W-1:0]  total_count;
        logic [CNT_W-1:0]  lot1_count;
        logic [CNT_W-1:0]  lot2_count;
        logic [CNT_W-1:0]  lot1_display;
        logic [CNT_W-1:0]  lot2_display;
        logic [LIFE_W-1:0] life_count;
        logic              values_changed;
        logic [1:0]        lot_reached_clear;
    } out_word_t;

    typedef struct packed {
        logic [2:0]       counter_present;
        logic [2:0]       counter_in_use;
        logic [2:0]       external_source;
        logic [CNT_W-1:0] lot1_preset;
        logic [CNT_W-1:0] lot2_preset;
        logic             show_remaining;
    } cfg_t;

    typedef struct packed {
        logic advance;
        logic pending;
        logic external;
        logic enable;
        logic cmd_level;
        logic clear;
        logic use_preset;
    } lane_ctrl_t;

endpackage

/* rtl/pslc_cfg_regs.sv */
// Configuration register file of the press stroke lot counter.
`timescale 1ns / 1ps

module pslc_cfg_regs
    import pslc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PRESENT:     cfg_next.counter_present = cfg_data[2:0];
                REG_IN_USE:      cfg_next.counter_in_use  = cfg_data[2:0];
                REG_EXTERNAL:    cfg_next.external_source = cfg_data[2:0];
                REG_LOT1_PRESET: cfg_next.lot1_preset     = cfg_data;
                REG_LOT2_PRESET: cfg_next.lot2_preset     = cfg_data;
                REG_SHOW_REMAIN: cfg_next.show_remaining  = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/pslc_count_lane.sv */
// One counter lane: stroke phase, count bit edge history and the count itself.
`timescale 1ns / 1ps

module pslc_count_lane
    import pslc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  lane_ctrl_t       ctrl,
    input  logic [CNT_W-1:0] preset,
    output logic [CNT_W-1:0] count_next
);

    logic             phase_reg;
    logic             phase_next;
    logic             hist_reg;
    logic             hist_next;
    logic [CNT_W-1:0] count_reg;
    logic             inc;
    logic             grow;
    logic [CNT_W-1:0] sum;
    logic [CNT_W-1:0] bumped;

    always_comb
    begin
        phase_next = phase_reg;
        hist_next  = hist_reg;
        inc        = 1'b0;
        if (!ctrl.external)
        begin
            // count on the first tick of a pending stroke, release on the second
            if (ctrl.pending && !phase_reg)
            begin
                inc        = ctrl.enable;
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
            end
        end
        else
        begin
            inc       = ctrl.enable && ctrl.cmd_level && !hist_reg;
            hist_next = ctrl.cmd_level;
        end
    end

    // lot lanes stop at their preset, every lane wraps above the limit
    assign grow   = !ctrl.use_preset || (count_reg < preset);
    assign sum    = grow ? count_reg + CNT_W'(1) : count_reg;
    assign bumped = (sum > COUNT_MAX) ? '0 : sum;

    assign count_next = ctrl.clear ? '0 : (inc ? bumped : count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            hist_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            phase_reg <= phase_next;
            hist_reg  <= hist_next;
            count_reg <= count_next;
        end
    end

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.advance && ctrl.clear |=> count_reg == '0)
        else $error("lane count not cleared by reset edge");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.advance |=> $stable(count_reg))
        else $error("lane count moved without a tick");

    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("lane count above limit");

endmodule

/* rtl/press_stroke_lot_counter.sv */
// Top level of the press stroke lot counter: word registers, life counter, lanes.
// Accepted words wait in the input register; results go to the result register.
// Throughput: one word per cycle unless the result stalls; the two registers
// part the two sides, so a stalled result holds only the word behind it.
// Reset: rst_n clears all counters, stroke and edge history, configuration and
// the valid flags of both word registers at once; no clearing pass follows.
`timescale 1ns / 1ps

module press_stroke_lot_counter
    import pslc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  in_word_t         item,
    output logic             result_valid,
    input  logic             result_ready,
    output out_word_t        result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0] cfg_data
);

    cfg_t              cfg;

    // Input word register
    logic              in_valid_reg;
    in_word_t          in_word_reg;

    // Result word register
    logic              out_valid_reg;
    out_word_t         out_word_reg;
    out_word_t         out_word_next;

    // Tick state kept at the top: stroke latch, life counter, command history
    logic              pending_reg;
    logic              pending_next;
    logic              life_phase_reg;
    logic              life_phase_next;
    logic [LIFE_W-1:0] life_reg;
    logic [LIFE_W-1:0] life_next;
    logic [CMD_W-1:0]  prev_cmd_reg;

    logic              advance;
    logic              pend_in;
    logic [CMD_W-1:0]  cmd;
    logic [CMD_W-1:0]  rise;
    logic [2:0]        fit;
    lane_ctrl_t        total_ctrl;
    lane_ctrl_t        lot1_ctrl;
    lane_ctrl_t        lot2_ctrl;
    logic [CNT_W-1:0]  total_next;
    logic [CNT_W-1:0]  lot1_next;
    logic [CNT_W-1:0]  lot2_next;

    pslc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Move the held word into the result register whenever that slot frees up
    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;

    assign cmd  = in_word_reg.command_word;
    assign rise = ~prev_cmd_reg & cmd;
    assign fit  = cfg.counter_present & cfg.counter_in_use;

    // Life counter runs first and may drop the pending stroke
    always_comb
    begin
        pend_in         = pending_reg || in_word_reg.stroke_event;
        pending_next    = pend_in;
        life_next       = life_reg;
        life_phase_next = 1'b0;
        if (pend_in)
        begin
            if (!life_phase_reg)
            begin
                life_next       = life_reg + LIFE_W'(1);
                life_phase_next = 1'b1;
            end
            else
            begin
                pending_next = 1'b0;
            end
        end
    end

    // Lanes see the pending bit as the life counter leaves it
    always_comb
    begin
        total_ctrl.advance    = advance;
        total_ctrl.pending    = pending_next;
        total_ctrl.external   = cfg.external_source[0];
        total_ctrl.enable     = fit[0] && !cmd[CMD_TOTAL_RESET];
        total_ctrl.cmd_level  = cmd[CMD_TOTAL_COUNT];
        total_ctrl.clear      = rise[CMD_TOTAL_RESET];
        total_ctrl.use_preset = 1'b0;

        lot1_ctrl.advance     = advance;
        lot1_ctrl.pending     = pending_next;
        lot1_ctrl.external    = cfg.external_source[1];
        lot1_ctrl.enable      = fit[1] && !in_word_reg.lot_reached[0] && !cmd[CMD_LOT1_RESET];
        lot1_ctrl.cmd_level   = cmd[CMD_LOT1_COUNT];
        lot1_ctrl.clear       = rise[CMD_LOT1_RESET];
        lot1_ctrl.use_preset  = 1'b1;

        lot2_ctrl.advance     = advance;
        lot2_ctrl.pending     = pending_next;
        lot2_ctrl.external    = cfg.external_source[2];
        lot2_ctrl.enable      = fit[2] && !in_word_reg.lot_reached[1] && !cmd[CMD_LOT2_RESET];
        lot2_ctrl.cmd_level   = cmd[CMD_LOT2_COUNT];
        lot2_ctrl.clear       = rise[CMD_LOT2_RESET];
        lot2_ctrl.use_preset  = 1'b1;
    end

    pslc_count_lane u_total (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (total_ctrl),
        .preset     (COUNT_MAX),
        .count_next (total_next)
    );

    pslc_count_lane u_lot1 (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (lot1_ctrl),
        .preset     (cfg.lot1_preset),
        .count_next (lot1_next)
    );

    pslc_count_lane u_lot2 (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (lot2_ctrl),
        .preset     (cfg.lot2_preset),
        .count_next (lot2_next)
    );

    // Assemble the result word; display shows count or remaining, clamped at zero
    always_comb
    begin
        out_word_next.total_count = total_next;
        out_word_next.lot1_count  = lot1_next;
        out_word_next.lot2_count  = lot2_next;
        out_word_next.life_count  = life_next;
        if (cfg.show_remaining)
        begin
            out_word_next.lot1_display = (lot1_next > cfg.lot1_preset) ? '0
                                         : cfg.lot1_preset - lot1_next;
            out_word_next.lot2_display = (lot2_next > cfg.lot2_preset) ? '0
                                         : cfg.lot2_preset - lot2_next;
        end
        else
        begin
            out_word_next.lot1_display = lot1_next;
            out_word_next.lot2_display = lot2_next;
        end
        // total 2 reset has no counter here but still flags a change
        out_word_next.values_changed = rise[CMD_TOTAL_RESET] || rise[CMD_TOTAL2_RESET]
                                       || rise[CMD_LOT1_RESET] || rise[CMD_LOT2_RESET];
        out_word_next.lot_reached_clear = {rise[CMD_LOT2_RESET], rise[CMD_LOT1_RESET]};
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pending_reg    <= 1'b0;
            life_phase_reg <= 1'b0;
            life_reg       <= '0;
            prev_cmd_reg   <= '0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                pending_reg    <= pending_next;
                life_phase_reg <= life_phase_next;
                life_reg       <= life_next;
                prev_cmd_reg   <= cmd;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            in_word_reg <= item;
        end
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("advanced word did not reach the result register");

    a_clear_flags_change: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.lot_reached_clear != 2'b00) |-> result.values_changed)
        else $error("lot flag clear without change pulse");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.total_count <= COUNT_MAX)
        else $error("total count above limit");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> in_valid_reg && out_valid_reg && !result_ready)
        else $error("input stalled without a blocked result");

endmodule
